// ----- rtl/owbt_pkg.sv -----
`default_nettype none

package owbt_pkg;

    // payload widths of the channels
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned STORED_W    = 6;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam int unsigned DUR_W       = 12;
    localparam int unsigned BYTE_W      = 8;

    // default tick counter width
    localparam int unsigned COUNT_WIDTH_DEF = 12;

    // register reset values
    localparam logic [DUR_W-1:0]  DETECT_HIGH_RST = 12'd300;
    localparam logic [DUR_W-1:0]  DETECT_LOW_RST  = 12'd600;
    localparam logic [DUR_W-1:0]  WINDOW_HIGH_RST = 12'd700;
    localparam logic [DUR_W-1:0]  SHORT_RST       = 12'd10;
    localparam logic [DUR_W-1:0]  LONG_RST        = 12'd40;
    localparam logic [DUR_W-1:0]  OFF_HOLD_RST    = 12'd3000;
    localparam logic [BYTE_W-1:0] ADDRESS_RST     = 8'h72;

    // level handling
    localparam logic [STORED_W-1:0] LEVEL_MAX     = 6'd32;
    localparam logic [STORED_W-1:0] LEVEL_SAT     = 6'd30;
    localparam logic [4:0]          DATA_SAT      = 5'd26;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_HIGH = 3'd0,
        CFG_DETECT_LOW  = 3'd1,
        CFG_WINDOW_HIGH = 3'd2,
        CFG_SHORT       = 3'd3,
        CFG_LONG        = 3'd4,
        CFG_OFF_HOLD    = 3'd5,
        CFG_ADDRESS     = 3'd6
    } t_cfg_idx;

endpackage

`default_nettype wire

// ----- rtl/owbt_if.sv -----
`default_nettype none

// tick items into the transmitter
interface owbt_in_if
    import owbt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [LEVEL_W-1:0]   level;

    modport source (output valid, output operation, output level, input ready);
    modport sink   (input valid, input operation, input level, output ready);
endinterface

// per-tick result items
interface owbt_out_if
    import owbt_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 line;
    logic                 busy_res;
    logic [STORED_W-1:0]  stored_level;
    logic                 request_dropped;

    modport source (output valid, output line, output busy_res, output stored_level,
                    output request_dropped, input ready);
    modport sink   (input valid, input line, input busy_res, input stored_level,
                    input request_dropped, output ready);
endinterface

// register write channel
interface owbt_cfg_if
    import owbt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/one_wire_backlight_transmitter_top.sv -----
// channel   dir  handshake      payload
// i_in      in   valid/ready    operation[0], level[7:0]
// o_out     out  valid/ready    line, busy_res, stored_level[5:0], request_dropped
// i_cfg     in   valid/ready    index[2:0], data[11:0] (always ready)
//
// one item per clock while o_out is not stalled: each accepted tick updates the sequencer state and loads
// the result register in the same cycle, and that register drives o_out from the next cycle on
// a new tick is taken whenever the result register is empty or being drained
// i_rst_n is synchronous; registers return to their documented defaults,
// the line is driven low and one-wire mode is left
// a stall on o_out holds the result and the sequencer; no tick is lost
`default_nettype none

module one_wire_backlight_transmitter_top
    import owbt_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    owbt_in_if.sink     i_in,
    owbt_out_if.source  o_out,
    owbt_cfg_if.sink    i_cfg
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_OFF      = 4'd1,
        PH_DET_HIGH = 4'd2,
        PH_DET_LOW  = 4'd3,
        PH_DET_WIN  = 4'd4,
        PH_START    = 4'd5,
        PH_BIT_LOW  = 4'd6,
        PH_BIT_HIGH = 4'd7,
        PH_END      = 4'd8
    } t_phase;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // duration to counter load value, zero lasts one tick
    function automatic t_count f_load(input logic [DUR_W-1:0] dur);
        t_count c;
        c = COUNT_WIDTH'(dur);
        return (c == '0) ? COUNT_WIDTH'(1) : c;
    endfunction

    // configuration registers
    logic [DUR_W-1:0]  r_det_high, r_det_low, r_win_high, r_short, r_long, r_off_hold;
    logic [BYTE_W-1:0] r_address;

    // sequencer state
    t_phase              r_phase, a_phase, n_phase;
    t_count              r_count, a_count, n_count, cnt_dec;
    logic [BYTE_W-1:0]   r_shift, a_shift, n_shift, shift_nx;
    logic [3:0]          r_bidx, a_bidx, n_bidx, bidx_nx;
    logic [BYTE_W-1:0]   r_data, a_data;
    logic                r_sending, a_sending, n_sending;
    logic                r_active, n_active;
    logic [STORED_W-1:0] r_held, a_held, lvl;
    logic                r_line, a_line, n_line;
    logic [6:0]          lvl_x3;
    logic                dropped;

    // result register
    logic                r_out_valid;
    logic                r_res_line, r_res_busy, r_res_dropped;
    logic [STORED_W-1:0] r_res_level;

    logic in_acc;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_high <= DETECT_HIGH_RST;
            r_det_low  <= DETECT_LOW_RST;
            r_win_high <= WINDOW_HIGH_RST;
            r_short    <= SHORT_RST;
            r_long     <= LONG_RST;
            r_off_hold <= OFF_HOLD_RST;
            r_address  <= ADDRESS_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_DETECT_HIGH: r_det_high <= i_cfg.data;
                CFG_DETECT_LOW:  r_det_low  <= i_cfg.data;
                CFG_WINDOW_HIGH: r_win_high <= i_cfg.data;
                CFG_SHORT:       r_short    <= i_cfg.data;
                CFG_LONG:        r_long     <= i_cfg.data;
                CFG_OFF_HOLD:    r_off_hold <= i_cfg.data;
                CFG_ADDRESS:     r_address  <= i_cfg.data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp and data byte of a new request
    always_comb begin
        lvl    = (i_in.level > LEVEL_W'(LEVEL_MAX)) ? LEVEL_MAX : i_in.level[STORED_W-1:0];
        lvl_x3 = 7'(lvl) + {lvl, 1'b0};
    end

    // request intake: a request only starts from idle
    always_comb begin
        a_phase   = r_phase;
        a_count   = r_count;
        a_shift   = r_shift;
        a_bidx    = r_bidx;
        a_data    = r_data;
        a_sending = r_sending;
        a_held    = r_held;
        a_line    = r_line;
        dropped   = 1'b0;
        if (i_in.operation) begin
            if (r_phase != PH_IDLE) begin
                dropped = 1'b1;
            end else begin
                a_held = lvl;
                if (lvl == '0) begin
                    a_phase = PH_OFF;
                    a_line  = 1'b0;
                    a_count = f_load(r_off_hold);
                end else begin
                    a_data    = (lvl >= LEVEL_SAT) ? {3'b000, DATA_SAT}
                                                   : {3'b000, lvl_x3[6:2]};
                    a_sending = 1'b0;
                    if (!r_active) begin
                        a_phase = PH_DET_HIGH;
                        a_line  = 1'b1;
                        a_count = f_load(r_det_high);
                    end else begin
                        a_shift = r_address;
                        a_bidx  = '0;
                        a_phase = PH_START;
                        a_line  = 1'b1;
                        a_count = f_load(r_short);
                    end
                end
            end
        end
    end

    // tick countdown and phase sequencing
    always_comb begin
        n_phase   = a_phase;
        n_count   = a_count;
        n_shift   = a_shift;
        n_bidx    = a_bidx;
        n_sending = a_sending;
        n_active  = r_active;
        n_line    = a_line;
        cnt_dec   = a_count - COUNT_WIDTH'(1);
        shift_nx  = {a_shift[BYTE_W-2:0], 1'b0};
        bidx_nx   = a_bidx + 4'd1;
        if (a_phase != PH_IDLE) begin
            n_count = cnt_dec;
            if (cnt_dec == '0) begin
                case (a_phase)
                    PH_OFF: begin
                        n_phase  = PH_IDLE;
                        n_line   = 1'b0;
                        n_active = 1'b0;
                        n_count  = '0;
                    end
                    PH_DET_HIGH: begin
                        n_phase = PH_DET_LOW;
                        n_line  = 1'b0;
                        n_count = f_load(r_det_low);
                    end
                    PH_DET_LOW: begin
                        n_phase = PH_DET_WIN;
                        n_line  = 1'b1;
                        n_count = f_load(r_win_high);
                    end
                    PH_DET_WIN: begin
                        n_active = 1'b1;
                        n_shift  = r_address;
                        n_bidx   = '0;
                        n_phase  = PH_START;
                        n_line   = 1'b1;
                        n_count  = f_load(r_short);
                    end
                    PH_START: begin
                        n_phase = PH_BIT_LOW;
                        n_line  = 1'b0;
                        n_count = a_shift[BYTE_W-1] ? f_load(r_short) : f_load(r_long);
                    end
                    PH_BIT_LOW: begin
                        n_phase = PH_BIT_HIGH;
                        n_line  = 1'b1;
                        n_count = a_shift[BYTE_W-1] ? f_load(r_long) : f_load(r_short);
                    end
                    PH_BIT_HIGH: begin
                        n_shift = shift_nx;
                        n_bidx  = bidx_nx;
                        n_line  = 1'b0;
                        if (bidx_nx >= 4'd8) begin
                            n_phase = PH_END;
                            n_count = f_load(r_short);
                        end else begin
                            n_phase = PH_BIT_LOW;
                            n_count = shift_nx[BYTE_W-1] ? f_load(r_short)
                                                         : f_load(r_long);
                        end
                    end
                    PH_END: begin
                        if (!a_sending) begin
                            n_sending = 1'b1;
                            n_shift   = a_data;
                            n_bidx    = '0;
                            n_phase   = PH_START;
                            n_line    = 1'b1;
                            n_count   = f_load(r_short);
                        end else begin
                            n_sending = 1'b0;
                            n_phase   = PH_IDLE;
                            n_line    = 1'b1;
                            n_count   = '0;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end
                endcase
            end
        end
    end

    // state and result register, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_shift     <= '0;
            r_bidx      <= '0;
            r_data      <= '0;
            r_sending   <= 1'b0;
            r_active    <= 1'b0;
            r_held      <= '0;
            r_line      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase       <= n_phase;
                r_count       <= n_count;
                r_shift       <= n_shift;
                r_bidx        <= n_bidx;
                r_data        <= a_data;
                r_sending     <= n_sending;
                r_active      <= n_active;
                r_held        <= a_held;
                r_line        <= n_line;
                r_out_valid   <= 1'b1;
                r_res_line    <= a_line;
                r_res_busy    <= (a_phase != PH_IDLE);
                r_res_level   <= a_held;
                r_res_dropped <= dropped;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.line            = r_res_line;
    assign o_out.busy_res        = r_res_busy;
    assign o_out.stored_level    = r_res_level;
    assign o_out.request_dropped = r_res_dropped;

    // idle exactly when the tick counter is spent
    a_idle_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) == (r_count == '0))
        else $error("phase and tick counter disagree");

    // a request during a running sequence is reported as dropped
    a_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.operation && r_phase != PH_IDLE)
        |=> (o_out.valid && o_out.request_dropped && o_out.busy_res))
        else $error("busy request not flagged");

    // stored level never exceeds the clamp
    a_level : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= LEVEL_MAX)
        else $error("stored level above clamp");

    // bit counter stays within one byte while bits are sent
    a_bits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BIT_LOW || r_phase == PH_BIT_HIGH) |-> (r_bidx < 4'd8))
        else $error("bit index past byte end");

endmodule

`default_nettype wire

// ----- sim/owbt_checker.sv -----
`default_nettype none

module owbt_checker
    import owbt_pkg::*;
#(
    parameter int unsigned COUNT_W = COUNT_WIDTH_DEF
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    owbt_in_if    i_in,
    owbt_out_if   i_out,
    owbt_cfg_if   i_cfg,
    output int    o_fail_count,
    output int    o_pending,
    output logic  o_seq_idle
);

    // waveform phases of the transmitter
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_OFF,
        SEQ_DET_HIGH,
        SEQ_DET_LOW,
        SEQ_DET_WIN,
        SEQ_START,
        SEQ_BIT_LOW,
        SEQ_BIT_HIGH,
        SEQ_END
    } t_seq_phase;

    // one result item per tick
    typedef struct packed {
        logic                line;
        logic                busy;
        logic [STORED_W-1:0] stored;
        logic                dropped;
    } t_tick_result;

    // register copies
    logic [DUR_W-1:0]  t_det_high, t_det_low, t_win_high, t_short, t_long, t_off;
    logic [BYTE_W-1:0] dev_addr;

    // sequencer copy
    t_seq_phase          seq_phase;
    logic [COUNT_W-1:0]  tick_left;
    logic [BYTE_W-1:0]   shift_reg;
    logic [3:0]          bit_cnt;
    logic [BYTE_W-1:0]   level_code;
    logic                second_byte;
    logic                mode_entered;
    logic [STORED_W-1:0] level_kept;
    logic                pin;

    t_tick_result tick_results_due[$];
    int           fails = 0;

    function automatic void clear_transmitter();
        t_det_high   = DETECT_HIGH_RST;
        t_det_low    = DETECT_LOW_RST;
        t_win_high   = WINDOW_HIGH_RST;
        t_short      = SHORT_RST;
        t_long       = LONG_RST;
        t_off        = OFF_HOLD_RST;
        dev_addr     = ADDRESS_RST;
        seq_phase    = SEQ_IDLE;
        tick_left    = '0;
        shift_reg    = '0;
        bit_cnt      = '0;
        level_code   = '0;
        second_byte  = 1'b0;
        mode_entered = 1'b0;
        level_kept   = '0;
        pin          = 1'b0;
    endfunction

    // a zero duration after truncation still lasts one tick
    function automatic void load_phase(t_seq_phase ph, logic lv, logic [DUR_W-1:0] dur);
        logic [COUNT_W-1:0] c;
        c         = COUNT_W'(dur);
        seq_phase = ph;
        pin       = lv;
        tick_left = (c == '0) ? COUNT_W'(1) : c;
    endfunction

    function automatic void load_byte(logic [BYTE_W-1:0] b);
        shift_reg = b;
        bit_cnt   = '0;
        load_phase(SEQ_START, 1'b1, t_short);
    endfunction

    // one bit: short low for a one, long low for a zero
    function automatic void next_bit();
        load_phase(SEQ_BIT_LOW, 1'b0, shift_reg[BYTE_W-1] ? t_short : t_long);
    endfunction

    function automatic void take_level(logic [LEVEL_W-1:0] lvl);
        int unsigned l;
        int unsigned code;
        l = 32'(lvl);
        if (l > LEVEL_MAX) l = LEVEL_MAX;
        level_kept = STORED_W'(l);
        if (l == 0) begin
            load_phase(SEQ_OFF, 1'b0, t_off);
        end else begin
            code        = (l >= LEVEL_SAT) ? 32'(DATA_SAT) : (l * 3) / 4;
            level_code  = {3'b000, code[4:0]};
            second_byte = 1'b0;
            if (!mode_entered) load_phase(SEQ_DET_HIGH, 1'b1, t_det_high);
            else load_byte(dev_addr);
        end
    endfunction

    function automatic void advance_phase();
        case (seq_phase)
            SEQ_OFF: begin
                seq_phase    = SEQ_IDLE;
                pin          = 1'b0;
                mode_entered = 1'b0;
                tick_left    = '0;
            end
            SEQ_DET_HIGH: load_phase(SEQ_DET_LOW, 1'b0, t_det_low);
            SEQ_DET_LOW:  load_phase(SEQ_DET_WIN, 1'b1, t_win_high);
            SEQ_DET_WIN: begin
                mode_entered = 1'b1;
                load_byte(dev_addr);
            end
            SEQ_START:    next_bit();
            SEQ_BIT_LOW:  load_phase(SEQ_BIT_HIGH, 1'b1, shift_reg[BYTE_W-1] ? t_long : t_short);
            SEQ_BIT_HIGH: begin
                shift_reg = shift_reg << 1;
                bit_cnt   = bit_cnt + 1'b1;
                if (bit_cnt >= BYTE_W) load_phase(SEQ_END, 1'b0, t_short);
                else next_bit();
            end
            SEQ_END: begin
                // address byte done: follow with the data byte, else finish high
                if (!second_byte) begin
                    second_byte = 1'b1;
                    load_byte(level_code);
                end else begin
                    second_byte = 1'b0;
                    seq_phase   = SEQ_IDLE;
                    pin         = 1'b1;
                    tick_left   = '0;
                end
            end
            default: begin
                seq_phase = SEQ_IDLE;
                tick_left = '0;
            end
        endcase
    endfunction

    function automatic t_tick_result waveform_step(logic req, logic [LEVEL_W-1:0] lvl);
        t_tick_result r;
        r.dropped = 1'b0;
        if (req) begin
            if (seq_phase != SEQ_IDLE) r.dropped = 1'b1;
            else take_level(lvl);
        end
        r.line = pin;
        r.busy = (seq_phase != SEQ_IDLE);
        if (r.busy) begin
            tick_left = tick_left - 1'b1;
            if (tick_left == '0) advance_phase();
        end
        r.stored = level_kept;
        return r;
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_DETECT_HIGH: t_det_high = value;
            CFG_DETECT_LOW:  t_det_low  = value;
            CFG_WINDOW_HIGH: t_win_high = value;
            CFG_SHORT:       t_short    = value;
            CFG_LONG:        t_long     = value;
            CFG_OFF_HOLD:    t_off      = value;
            CFG_ADDRESS:     dev_addr   = value[BYTE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string field, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fails++;
        end
    endfunction

    // compare results, then follow ticks and register writes in order
    always @(posedge i_clk) begin
        t_tick_result got;
        t_tick_result want;
        if (!i_rst_n) begin
            clear_transmitter();
            tick_results_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.line    = i_out.line;
                got.busy    = i_out.busy_res;
                got.stored  = i_out.stored_level;
                got.dropped = i_out.request_dropped;
                if (tick_results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fails++;
                end else begin
                    want = tick_results_due.pop_front();
                    check_field("line", want.line, got.line);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("stored_level", want.stored, got.stored);
                    check_field("request_dropped", want.dropped, got.dropped);
                end
            end
            // a tick taken on the same edge as a write still sees the old value
            if (i_in.valid && i_in.ready)
                tick_results_due.push_back(waveform_step(i_in.operation, i_in.level));
            if (i_cfg.valid && i_cfg.ready) write_register(i_cfg.index, i_cfg.data);
        end
        o_fail_count <= fails;
        o_pending    <= tick_results_due.size();
        o_seq_idle   <= (seq_phase == SEQ_IDLE);
    end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`default_nettype none

module testbench;
    import owbt_pkg::*;

    localparam logic                 OP_TICK        = 1'b0;
    localparam logic                 OP_REQUEST     = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE      = 3'd7;
    localparam int unsigned          TIMEOUT_CYCLES = 2_000_000;
    localparam int                   RANDOM_ROUNDS  = 2;
    localparam int                   ROUND_ITEMS    = 50;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        idle_on;
    int          stall_left = 0;
    int unsigned cycles = 0;
    int          fail_count;
    int          pending;
    logic        seq_idle;

    // directed levels: first block with short timing, last four with zero timing
    logic [LEVEL_W-1:0] probe_levels [13] = '{
        8'd1, 8'd4, 8'd29, 8'd30, 8'd32, 8'd255, 8'd0, 8'd0, 8'd20,
        8'd1, 8'd32, 8'd0, 8'd5
    };

    owbt_in_if  in_ch();
    owbt_out_if out_ch();
    owbt_cfg_if cfg_ch();

    one_wire_backlight_transmitter_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    owbt_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_seq_idle   (seq_idle)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result side stalls in bursts, started at random while idle_on is set
    always @(posedge clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 15) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 11);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == TIMEOUT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one tick item, optionally after a burst of idle cycles
    task automatic send_tick(logic op, logic [LEVEL_W-1:0] lvl);
        int gap;
        if (idle_on && $urandom_range(0, 15) == 0) begin
            gap = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.level     <= lvl;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // plain ticks until the predicted sequencer is idle
    task automatic run_until_idle();
        send_tick(OP_TICK, LEVEL_W'($urandom));
        while (!seq_idle) send_tick(OP_TICK, LEVEL_W'($urandom));
    endtask

    // hold off until every result has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_timing(input logic [DUR_W-1:0] det_hi, det_lo, win_hi, short_t,
                              long_t, off_t, input logic [CFG_DATA_W-1:0] addr,
                              input bit spare);
        write_reg(CFG_DETECT_HIGH, det_hi);
        write_reg(CFG_DETECT_LOW, det_lo);
        write_reg(CFG_WINDOW_HIGH, win_hi);
        write_reg(CFG_SHORT, short_t);
        write_reg(CFG_LONG, long_t);
        write_reg(CFG_OFF_HOLD, off_t);
        write_reg(CFG_ADDRESS, addr);
        if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // request, plain tick, a second request (dropped while the sequence still runs), then finish the sequence
    task automatic probe(int first, int last);
        for (int i = first; i <= last; i++) begin
            send_tick(OP_REQUEST, probe_levels[i]);
            send_tick(OP_TICK, ~probe_levels[i]);
            send_tick(OP_REQUEST, ~probe_levels[i]);
            run_until_idle();
        end
        settle();
    endtask

    // random requests over short random timing, mostly started from idle
    task automatic random_round(bit pause_midway);
        logic               req;
        logic [LEVEL_W-1:0] lvl;
        set_timing(DUR_W'($urandom_range(0, 12)), DUR_W'($urandom_range(0, 12)),
                   DUR_W'($urandom_range(0, 12)), DUR_W'($urandom_range(0, 3)),
                   DUR_W'($urandom_range(0, 6)), DUR_W'($urandom_range(0, 20)),
                   CFG_DATA_W'($urandom), 1'($urandom_range(0, 1)));
        for (int i = 0; i < ROUND_ITEMS; i++) begin
            if (pause_midway && i == ROUND_ITEMS / 2) settle();
            req = ($urandom_range(0, 15) == 0) || (seq_idle && $urandom_range(0, 2) == 0);
            case ($urandom_range(0, 7))
                0:       lvl = '0;
                1, 2:    lvl = LEVEL_W'($urandom_range(33, 255));
                default: lvl = LEVEL_W'($urandom_range(1, 32));
            endcase
            send_tick(req ? OP_REQUEST : OP_TICK, lvl);
        end
        run_until_idle();
        settle();
    endtask

    initial begin
        rst_n           = 1'b0;
        idle_on         = 1'b1;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.level     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_DETECT_HIGH;
        cfg_ch.data     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing: saturated level with a dropped request
        send_tick(OP_REQUEST, 8'd31);
        repeat (3) send_tick(OP_TICK, 8'hAA);
        send_tick(OP_REQUEST, 8'd7);
        settle();

        // short timing takes over from the detect low pulse on, level corners
        set_timing(12'd3, 12'd4, 12'd5, 12'd1, 12'd2, 12'd6, 12'h0A5, 1'b0);
        run_until_idle();
        settle();
        probe(0, 8);

        // zero durations, address with upper data bits set, unused index
        set_timing('0, '0, '0, '0, '0, '0, 12'hF00, 1'b1);
        probe(9, 12);

        // random rounds, the last one without idling
        for (int r = 0; r < RANDOM_ROUNDS; r++) begin
            idle_on <= (r != RANDOM_ROUNDS - 1);
            random_round(r == 1);
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
